// ===== rtl/b64d_pkg.sv =====
// shared types, constants and the sextet lookup for the base64 stream decoder
`timescale 1ns / 1ps

package b64d_pkg;

	localparam int FifoDepth = 8;
	localparam int PtrW = $clog2(FifoDepth);
	localparam int CntW = PtrW + 1;
	// worst case of three results per item must still fit
	localparam logic [CntW-1:0] FifoThresh = CntW'(FifoDepth - 3);

	localparam logic [7:0] ChPad = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       message_done;
	} res_t;

	// {hit, sextet}; hit low for characters outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B || c == 8'h2D) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F || c == 8'h5F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

// ===== rtl/base64url_stream_decoder_top.sv =====
// an accepted item is registered in the input stage; its results then enter the result queue that drives the output
// throughput: one item per cycle while the result queue has room; a group's fourth sextet queues three bytes at once
// input accepted while the input stage is empty or the 8-entry result queue has room for three more results
// sustained rate set by the single byte output port (4 items give 3 bytes)
// arst_n clears the input stage valid, queue pointers and decode state to zero
`timescale 1ns / 1ps

module base64url_stream_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       end_marker,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       message_done
);

	logic                     v_s1;
	logic [7:0]               char_s1;
	logic                     end_s1;
	logic                     go;

	logic [1:0]               phase_q, phase_n;
	logic [17:0]              held_q, held_n;
	logic                     pad_q, pad_n;

	logic [6:0]               sx;
	logic [23:0]              word;
	logic [1:0]               push_n;
	b64d_pkg::res_t           res [3];

	b64d_pkg::res_t           mem_q [b64d_pkg::FifoDepth];
	logic [b64d_pkg::PtrW-1:0] wr_q, rd_q;
	logic [b64d_pkg::CntW-1:0] cnt_q;
	logic                     pop;

	assign go       = v_s1 && (cnt_q <= b64d_pkg::FifoThresh);
	assign in_ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			char_s1 <= char_code;
			end_s1  <= end_marker;
		end
	end

	// decode and group assembly
	assign sx   = b64d_pkg::sextet_of(char_s1);
	assign word = {held_q, sx[5:0]};

	always_comb begin
		phase_n = phase_q;
		held_n  = held_q;
		pad_n   = pad_q;
		push_n  = 2'd0;
		for (int k = 0; k < 3; k++) begin
			res[k] = '0;
		end
		if (end_s1) begin
			phase_n = 2'd0;
			held_n  = '0;
			pad_n   = 1'b0;
			unique case (phase_q)
				2'd2: begin
					push_n = 2'd1;
					res[0] = '{held_q[11:4], 1'b1, 1'b1};
				end
				2'd3: begin
					push_n = 2'd2;
					res[0] = '{held_q[17:10], 1'b1, 1'b0};
					res[1] = '{held_q[9:2], 1'b1, 1'b1};
				end
				default: begin
					push_n = 2'd1;
					res[0] = '{8'd0, 1'b0, 1'b1};
				end
			endcase
		end else if (!pad_q) begin
			if (char_s1 == b64d_pkg::ChPad) begin
				pad_n = 1'b1;
			end else if (sx[6]) begin
				if (phase_q == 2'd3) begin
					push_n  = 2'd3;
					res[0]  = '{word[23:16], 1'b1, 1'b0};
					res[1]  = '{word[15:8], 1'b1, 1'b0};
					res[2]  = '{word[7:0], 1'b1, 1'b0};
					held_n  = '0;
					phase_n = 2'd0;
				end else begin
					held_n  = word[17:0];
					phase_n = phase_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			held_q  <= '0;
			pad_q   <= 1'b0;
		end else if (go) begin
			phase_q <= phase_n;
			held_q  <= held_n;
			pad_q   <= pad_n;
		end
	end

	// result queue
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign data_byte    = mem_q[rd_q].data_byte;
	assign byte_valid   = mem_q[rd_q].byte_valid;
	assign message_done = mem_q[rd_q].message_done;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (go && (2'(k) < push_n)) begin
				mem_q[wr_q + b64d_pkg::PtrW'(k)] <= res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (go) begin
				wr_q <= wr_q + b64d_pkg::PtrW'(push_n);
			end
			if (pop) begin
				rd_q <= rd_q + b64d_pkg::PtrW'(1);
			end
			cnt_q <= cnt_q + (go ? b64d_pkg::CntW'(push_n) : '0)
				- b64d_pkg::CntW'(pop);
		end
	end

endmodule

// ===== rtl/b64d_checker.sv =====
// port-level assertions for the base64 stream decoder, bound to the top level
`timescale 1ns / 1ps

module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_byte,
	input logic       byte_valid,
	input logic       message_done
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(data_byte) && $stable(byte_valid)
			&& $stable(message_done))
		else $error("stalled result changed");

	// an empty result only closes a message
	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> message_done)
		else $error("empty result without message_done");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> data_byte == 8'd0)
		else $error("empty result carries a nonzero byte");

endmodule

bind base64url_stream_decoder_top b64d_checker u_b64d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.data_byte    (data_byte),
	.byte_valid   (byte_valid),
	.message_done (message_done)
);

// ===== tb/sv/tb.sv =====
// self-checking testbench for the base64 stream decoder: scoreboard class, drivers and phases
`timescale 1ns / 1ps

module tb;

	localparam int CycleLimit = 200000;
	localparam int PhaseItems = 56;

	class decode_scoreboard;
		b64d_pkg::res_t pending_bytes[$];
		logic [1:0]  sextet_count;
		logic [17:0] sextet_buf;
		logic        pad_hit;
		int errors;
		int checked;
		int closed;
		int accepted;

		function new();
			clear_group();
			pad_hit = 1'b0;
			errors = 0;
			checked = 0;
			closed = 0;
			accepted = 0;
		endfunction

		function void clear_group();
			sextet_count = 2'd0;
			sextet_buf = 18'd0;
		endfunction

		function int sextet_lookup(logic [7:0] c);
			string abc;
			abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
			if (c == "-") return 62;
			if (c == "_") return 63;
			for (int i = 0; i < 64; i++) begin
				if (abc[i] == c) return i;
			end
			return -1;
		endfunction

		function void push_byte(logic [7:0] d, logic v, logic m);
			b64d_pkg::res_t r;
			r.data_byte = d;
			r.byte_valid = v;
			r.message_done = m;
			pending_bytes.push_back(r);
		endfunction

		// predicts the results of one accepted item
		function void note_item(logic [7:0] c, logic e);
			int sx;
			logic [23:0] word;
			accepted++;
			if (e) begin
				case (sextet_count)
					2'd2: push_byte(sextet_buf[11:4], 1'b1, 1'b1);
					2'd3: begin
						push_byte(sextet_buf[17:10], 1'b1, 1'b0);
						push_byte(sextet_buf[9:2], 1'b1, 1'b1);
					end
					default: push_byte(8'h00, 1'b0, 1'b1);
				endcase
				closed++;
				clear_group();
				pad_hit = 1'b0;
				return;
			end
			if (pad_hit) return;
			if (c == b64d_pkg::ChPad) begin
				pad_hit = 1'b1;
				return;
			end
			sx = sextet_lookup(c);
			if (sx < 0) return;
			if (sextet_count == 2'd3) begin
				word = {sextet_buf, sx[5:0]};
				push_byte(word[23:16], 1'b1, 1'b0);
				push_byte(word[15:8], 1'b1, 1'b0);
				push_byte(word[7:0], 1'b1, 1'b0);
				clear_group();
			end else begin
				sextet_buf = {sextet_buf[11:0], sx[5:0]};
				sextet_count = sextet_count + 2'd1;
			end
		endfunction

		function void check_byte(logic [7:0] d, logic v, logic m);
			b64d_pkg::res_t want;
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected result data_byte %h byte_valid %b message_done %b",
					$time, d, v, m);
				errors++;
				return;
			end
			want = pending_bytes.pop_front();
			checked++;
			if (want.data_byte !== d) begin
				$display("%0t: data_byte expected %h actual %h", $time, want.data_byte, d);
				errors++;
			end
			if (want.byte_valid !== v) begin
				$display("%0t: byte_valid expected %b actual %b", $time, want.byte_valid, v);
				errors++;
			end
			if (want.message_done !== m) begin
				$display("%0t: message_done expected %b actual %b",
					$time, want.message_done, m);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = 8'h00;
	logic       end_marker = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_done;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;
	int item_count;
	string alpha_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_";
	logic [8:0] directed_items[$];

	decode_scoreboard sb = new();

	base64url_stream_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.end_marker(end_marker),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.message_done(message_done)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending_bytes.size());
			$display("base64url_stream_decoder_top test failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_byte(data_byte, byte_valid, message_done);
		end
	end

	task automatic send_item(logic [7:0] c, logic e);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_marker <= e;
		do @(posedge clk); while (!in_ready);
		sb.note_item(c, e);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_bytes.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] alpha_char();
		return alpha_set[$urandom_range(0, 65)];
	endfunction

	// mostly well-formed messages with noise, padding and the odd missing end marker
	task automatic send_random_messages(int n_items);
		int start_items;
		int len;
		start_items = sb.accepted;
		while (sb.accepted - start_items < n_items) begin
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
			end
			len = 4 * $urandom_range(0, 3) + $urandom_range(0, 3);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(8'($urandom_range(0, 255)), 1'b0);
				end else begin
					send_item(alpha_char(), 1'b0);
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				send_item(b64d_pkg::ChPad, 1'b0);
				repeat ($urandom_range(0, 3)) begin
					if ($urandom_range(0, 1)) send_item(alpha_char(), 1'b0);
					else send_item(8'($urandom_range(0, 255)), 1'b0);
				end
			end
			if ($urandom_range(0, 19) != 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end
		end
	endtask

	initial begin
		directed_items = '{
			{1'b0, "T"}, {1'b0, "W"}, 9'h000, {1'b0, "F"}, {1'b0, "u"},
			{1'b0, "/"}, {1'b0, "_"}, {1'b0, "-"}, {1'b0, "+"},
			{1'b0, "Z"}, {1'b0, "z"}, 9'h0FF, 9'h1A5,
			{1'b0, "a"}, {1'b0, "0"}, {1'b0, "9"}, 9'h15A,
			{1'b0, "A"}, 9'h1FF,
			9'h100,
			{1'b0, "Q"}, {1'b0, "="}, {1'b0, "Q"}, {1'b0, "Q"}, 9'h1C3
		};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_items[i]) send_item(directed_items[i][7:0], directed_items[i][8]);
		wait_for_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			send_random_messages(PhaseItems);
			// sender holds off until everything queued so far has come out
			wait_for_results();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);

		$display("run covered %0d accepted items in %0d messages, %0d results checked",
			sb.accepted, sb.closed, sb.checked);
		$display("directed edge cases then random messages under four idle/stall mixes");
		if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
			$display("base64url_stream_decoder_top test passed");
		end else begin
			$display("base64url_stream_decoder_top test failed");
		end
		$finish;
	end

endmodule
